@@ design/dpt_pkg.sv @@
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared widths, opcodes and count limits for the device presence table.
// ----------------------------------------------------------------------------
package dpt_pkg;

  // Field widths of one input word
  localparam int OP_W    = 3;
  localparam int DTYPE_W = 8;
  localparam int ADDR_W  = 16;
  localparam int KEY_W   = DTYPE_W + ADDR_W;

  // Heartbeat count
  localparam int HB_W = 8;
  localparam logic [HB_W-1:0] HB_INIT = 8'd1;
  localparam logic [HB_W-1:0] HB_MAX  = 8'hFF;

  // Opcodes
  typedef logic [OP_W-1:0] opcode_t;
  localparam opcode_t OP_CHECK   = 3'd0;
  localparam opcode_t OP_ADD     = 3'd1;
  localparam opcode_t OP_DELETE  = 3'd2;
  localparam opcode_t OP_HBEAT   = 3'd3;
  localparam opcode_t OP_CLR_ONE = 3'd4;
  localparam opcode_t OP_CLR_ALL = 3'd5;
  localparam opcode_t OP_PURGE   = 3'd6;

  // Lookup key as stored in the table
  typedef struct packed {
    logic [DTYPE_W-1:0] device_type;
    logic [ADDR_W-1:0]  short_addr;
  } key_t;

endpackage

@@ design/dpt_if.sv @@
// ----------------------------------------------------------------------------
// dpt_in_if / dpt_out_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface dpt_in_if;
  import dpt_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [DTYPE_W-1:0]  device_type;
  logic [ADDR_W-1:0]   short_addr;

  modport source (output valid, output opcode, output device_type, output short_addr,
                  input ready);
  modport sink   (input valid, input opcode, input device_type, input short_addr,
                  output ready);
endinterface

interface dpt_out_if;
  logic valid;
  logic ready;
  logic success;

  modport source (output valid, output success, input ready);
  modport sink   (input valid, input success, output ready);
endinterface

@@ design/device_presence_table_with_aging_top.sv @@
// ----------------------------------------------------------------------------
// device_presence_table_with_aging_top
// Table of known devices keyed by device type and short address, with an
// 8-bit saturating heartbeat count per entry.
// ----------------------------------------------------------------------------
// Each request word is handled by one linear pass over the table: the key and
// count memories are read one slot per cycle through a single read port, and
// one compare stage tracks the lowest matching slot and the lowest free slot.
// Every request scans all TABLE_DEPTH slots before its result is loaded, and
// the next request is accepted only after that load. in_if.ready is high only
// while no request is in progress. The result sits in an output register, so
// a new request may be accepted while the previous result waits to be taken.
// Valid bits are flip-flops cleared by reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module device_presence_table_with_aging_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  dpt_in_if.sink       in_if,
  dpt_out_if.source    out_if
);
  import dpt_pkg::*;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SCNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [SCNT_W-1:0] SCAN_END = SCNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t               state_r;
  opcode_t              op_r;
  key_t                 key_r;
  logic [TABLE_DEPTH-1:0] valid_r;

  // scan pipeline
  logic [SCNT_W-1:0]    rd_cnt_r;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_active;
  logic [IDX_W-1:0]     chk_idx_r;
  logic                 chk_vld_r;
  key_t                 key_rd_r;
  logic [HB_W-1:0]      cnt_rd_r;
  logic                 match;

  // scan results
  logic                 hit_found_r;
  logic [IDX_W-1:0]     hit_idx_r;
  logic [HB_W-1:0]      hit_cnt_r;
  logic                 free_found_r;
  logic [IDX_W-1:0]     free_idx_r;

  // finish and output
  logic                 fin_fire;
  logic                 ok;
  logic [HB_W-1:0]      hb_inc;
  logic                 out_valid_r;
  logic                 success_r;

  // memories
  key_t                 key_mem [TABLE_DEPTH];
  logic [HB_W-1:0]      cnt_mem [TABLE_DEPTH];
  logic                 key_we;
  logic                 cnt_we;
  logic [IDX_W-1:0]     cnt_wa;
  logic [HB_W-1:0]      cnt_wd;

  assign in_if.ready    = (state_r == ST_IDLE);
  assign out_if.valid   = out_valid_r;
  assign out_if.success = success_r;

  assign rd_idx    = rd_cnt_r[IDX_W-1:0];
  assign rd_active = (state_r == ST_SCAN) && (rd_cnt_r != SCAN_END);
  assign match     = valid_r[chk_idx_r] && (key_rd_r == key_r);
  assign fin_fire  = (state_r == ST_FINISH) && (!out_valid_r || out_if.ready);
  assign hb_inc    = (hit_cnt_r == HB_MAX) ? HB_MAX : hit_cnt_r + HB_W'(1);

  // success bit per opcode
  always_comb begin
    case (op_r)
      OP_CHECK, OP_DELETE, OP_HBEAT, OP_CLR_ONE: ok = hit_found_r;
      OP_ADD:                                    ok = !hit_found_r && free_found_r;
      OP_CLR_ALL, OP_PURGE:                      ok = 1'b1;
      default:                                   ok = 1'b0;
    endcase
  end

  // memory write selection
  always_comb begin
    key_we = fin_fire && (op_r == OP_ADD) && ok;
    cnt_we = 1'b0;
    cnt_wa = hit_idx_r;
    cnt_wd = '0;
    if (rd_active && (op_r == OP_CLR_ALL)) begin
      cnt_we = 1'b1;
      cnt_wa = rd_idx;
    end else if (fin_fire) begin
      case (op_r)
        OP_ADD: begin
          cnt_we = ok;
          cnt_wa = free_idx_r;
          cnt_wd = HB_INIT;
        end
        OP_HBEAT: begin
          cnt_we = hit_found_r;
          cnt_wd = hb_inc;
        end
        OP_CLR_ONE: begin
          cnt_we = hit_found_r;
        end
        default: begin
          cnt_we = 1'b0;
        end
      endcase
    end
  end

  // key and count memories, registered read
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[free_idx_r] <= key_r;
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    key_rd_r <= key_mem[rd_idx];
    cnt_rd_r <= cnt_mem[rd_idx];
  end

  // sequencer, valid bits and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
      chk_vld_r    <= 1'b0;
      rd_cnt_r     <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      // result taken and no new one loaded this cycle
      if (out_valid_r && out_if.ready && !fin_fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_if.valid) begin
            op_r              <= in_if.opcode;
            key_r.device_type <= in_if.device_type;
            key_r.short_addr  <= in_if.short_addr;
            rd_cnt_r          <= '0;
            chk_vld_r         <= 1'b0;
            hit_found_r       <= 1'b0;
            free_found_r      <= 1'b0;
            state_r           <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // issue stage
          if (rd_active) begin
            rd_cnt_r  <= rd_cnt_r + SCNT_W'(1);
            chk_idx_r <= rd_idx;
            chk_vld_r <= 1'b1;
          end else begin
            chk_vld_r <= 1'b0;
            state_r   <= ST_FINISH;
          end
          // compare stage
          if (chk_vld_r) begin
            if (!hit_found_r && match) begin
              hit_found_r <= 1'b1;
              hit_idx_r   <= chk_idx_r;
              hit_cnt_r   <= cnt_rd_r;
            end
            if (!free_found_r && !valid_r[chk_idx_r]) begin
              free_found_r <= 1'b1;
              free_idx_r   <= chk_idx_r;
            end
            if ((op_r == OP_PURGE) && valid_r[chk_idx_r] && (cnt_rd_r == '0)) begin
              valid_r[chk_idx_r] <= 1'b0;
            end
          end
        end
        ST_FINISH: begin
          if (fin_fire) begin
            out_valid_r <= 1'b1;
            success_r   <= ok;
            if ((op_r == OP_ADD) && ok) begin
              valid_r[free_idx_r] <= 1'b1;
            end
            if ((op_r == OP_DELETE) && hit_found_r) begin
              valid_r[hit_idx_r] <= 1'b0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the device presence table with aging.
// ----------------------------------------------------------------------------
// Request words go in on the input channel and each accepted word updates a
// shadow copy of the table, which gives the expected success bit. Result
// words are checked in order against those expectations. The stimulus has a
// short directed opening, then random chunks: mixed traffic over a small key
// pool, fill bursts that push the table to full, and heartbeat runs long
// enough to saturate a count. Both channels idle at random, except in one
// long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import dpt_pkg::*;

  localparam int SLOTS       = 16;
  localparam int RANDOM_WORDS = 1600;
  localparam int POOL_SIZE   = 24;
  localparam int IDLE_PCT    = 21;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = SLOTS + 8;
  localparam opcode_t OP_RESERVED = 3'd7;

  // Shadow of the device table; predicts success and tracks what was covered
  class presence_scoreboard;
    bit              slot_valid[SLOTS];
    key_t            slot_key[SLOTS];
    logic [HB_W-1:0] slot_count[SLOTS];
    bit              expected_success[$];
    int              mismatches;
    int              op_count[8];
    int              refused_full;
    int              refused_dup;
    int              beats_at_max;
    int              aged_out;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      foreach (op_count[i]) op_count[i] = 0;
      mismatches   = 0;
      refused_full = 0;
      refused_dup  = 0;
      beats_at_max = 0;
      aged_out     = 0;
    endfunction

    // Apply one accepted request to the shadow table and queue its answer
    function void note_request(opcode_t op, key_t key);
      int hit;
      int free_slot;
      bit ok;
      hit       = -1;
      free_slot = -1;
      ok        = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && slot_valid[i] && slot_key[i] == key) hit = i;
        if (free_slot < 0 && !slot_valid[i]) free_slot = i;
      end
      op_count[op]++;
      case (op)
        OP_CHECK: begin
          ok = (hit >= 0);
        end
        OP_ADD: begin
          if (hit >= 0) begin
            refused_dup++;
          end else if (free_slot < 0) begin
            refused_full++;
          end else begin
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot]   = key;
            slot_count[free_slot] = HB_INIT;
            ok = 1'b1;
          end
        end
        OP_DELETE: begin
          if (hit >= 0) begin
            slot_valid[hit] = 1'b0;
            ok = 1'b1;
          end
        end
        OP_HBEAT: begin
          if (hit >= 0) begin
            if (slot_count[hit] == HB_MAX) beats_at_max++;
            else slot_count[hit] = slot_count[hit] + 1'b1;
            ok = 1'b1;
          end
        end
        OP_CLR_ONE: begin
          if (hit >= 0) begin
            slot_count[hit] = '0;
            ok = 1'b1;
          end
        end
        OP_CLR_ALL: begin
          for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i]) slot_count[i] = '0;
          ok = 1'b1;
        end
        OP_PURGE: begin
          for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_count[i] == '0) begin
              slot_valid[i] = 1'b0;
              aged_out++;
            end
          ok = 1'b1;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
      expected_success.push_back(ok);
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void check_result(logic success);
      bit want;
      if (expected_success.size() == 0) begin
        $error("unexpected result word: success actual %0b, none expected", success);
        mismatches++;
      end else begin
        want = expected_success.pop_front();
        if (success !== want) begin
          $error("success mismatch: expected %0b, actual %0b", want, success);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_success.size();
    endfunction

    function void report_coverage();
      $display("covered %0d adds (%0d full, %0d dup), %0d deletes, %0d beats (%0d sat)",
               op_count[OP_ADD], refused_full, refused_dup, op_count[OP_DELETE],
               op_count[OP_HBEAT], beats_at_max);
      $display("  %0d checks, %0d clears, %0d clear-alls, %0d purges (%0d aged), %0d rsvd",
               op_count[OP_CHECK], op_count[OP_CLR_ONE], op_count[OP_CLR_ALL],
               op_count[OP_PURGE], aged_out, op_count[OP_RESERVED]);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  int   words_sent;
  key_t key_pool[POOL_SIZE];

  presence_scoreboard sb = new();

  dpt_in_if  in_ch();
  dpt_out_if out_ch();

  device_presence_table_with_aging_top #(.TABLE_DEPTH(SLOTS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random stalls except during the steady stretch
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitors: note accepted requests, check accepted results
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_request(in_ch.opcode, key_t'({in_ch.device_type, in_ch.short_addr}));
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.success);
  end

  // Watchdog: too long without any word moving on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Send one request word; valid stays high after acceptance unless an idle
  // gap comes before the next word
  task automatic send_word(opcode_t op, key_t key);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.device_type <= key.device_type;
    in_ch.short_addr  <= key.short_addr;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    steady = (words_sent >= 700 && words_sent < 950);
  endtask

  function automatic key_t any_key();
    key_t k;
    k.device_type = DTYPE_W'($urandom);
    k.short_addr  = ADDR_W'($urandom);
    return k;
  endfunction

  // Mostly pool keys so that lookups hit; a few keys from anywhere
  function automatic key_t pick_key();
    if ($urandom_range(99) < 94) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return any_key();
  endfunction

  function automatic opcode_t pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 30) return OP_ADD;
    if (r < 45) return OP_CHECK;
    if (r < 57) return OP_DELETE;
    if (r < 77) return OP_HBEAT;
    if (r < 86) return OP_CLR_ONE;
    if (r < 91) return OP_CLR_ALL;
    if (r < 97) return OP_PURGE;
    return OP_RESERVED;
  endfunction

  // Empty the table, add one key and beat it well past the count ceiling
  task automatic heartbeat_run(key_t key);
    send_word(OP_CLR_ALL, key);
    send_word(OP_PURGE, key);
    send_word(OP_ADD, key);
    repeat (258) send_word(OP_HBEAT, key);
    send_word(OP_CHECK, key);
  endtask

  // Stimulus
  initial begin
    key_t lo_key;
    key_t hi_key;
    key_t base;
    int   chunk;
    int   r;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_CHECK;
    in_ch.device_type <= '0;
    in_ch.short_addr  <= '0;
    steady     = 1'b0;
    words_sent = 0;

    // Key pool: unrelated keys, keys sharing a type, keys sharing an address
    base = any_key();
    foreach (key_pool[i]) begin
      key_pool[i] = any_key();
      if (i >= 8 && i < 16) key_pool[i].device_type = base.device_type;
      if (i >= 16) key_pool[i].short_addr = base.short_addr;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: empty table, extremes, duplicates, aging, reserved op
    lo_key = '0;
    hi_key = '1;
    send_word(OP_CHECK, lo_key);
    send_word(OP_DELETE, lo_key);
    send_word(OP_HBEAT, hi_key);
    send_word(OP_CLR_ONE, hi_key);
    send_word(OP_ADD, lo_key);
    send_word(OP_ADD, hi_key);
    send_word(OP_ADD, lo_key);
    send_word(OP_CHECK, hi_key);
    send_word(OP_HBEAT, hi_key);
    send_word(OP_CLR_ONE, lo_key);
    send_word(OP_PURGE, lo_key);
    send_word(OP_CHECK, lo_key);
    send_word(OP_HBEAT, hi_key);
    send_word(OP_CLR_ALL, lo_key);
    send_word(OP_PURGE, hi_key);
    send_word(OP_CHECK, hi_key);
    send_word(OP_ADD, key_pool[0]);
    send_word(OP_DELETE, key_pool[0]);
    send_word(OP_DELETE, key_pool[0]);
    send_word(OP_RESERVED, hi_key);

    // Random chunks; the first one always saturates a count
    chunk = 0;
    while (words_sent < 20 + RANDOM_WORDS) begin
      r = $urandom_range(99);
      if (chunk == 0 || (r < 6 && words_sent < RANDOM_WORDS - 300)) begin
        heartbeat_run(key_pool[$urandom_range(POOL_SIZE - 1)]);
      end else if (r < 28) begin
        // fill burst: drive the table to full and past it
        repeat (20) send_word(OP_ADD, $urandom_range(1) ? pick_key() : any_key());
      end else begin
        repeat (40) send_word(pick_op(), pick_key());
      end
      chunk++;
    end
    in_ch.valid <= 1'b0;

    // Drain, then give any stray result time to show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    sb.report_coverage();
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
